[src/mcts_pkg.sv]
// Shared types and fixed widths for the mip chain texture size block.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package mcts_pkg;

  localparam int unsigned LenW   = 36;  // byte length result
  localparam int unsigned SumW   = 30;  // any mip chain sum fits below 2^30
  localparam int unsigned DimW   = 13;  // width and height fields
  localparam int unsigned MulW   = 32;  // shared multiplier operand width
  localparam int unsigned RecipSh = 30; // reciprocal scale for the face alignment

  localparam logic [1:0] DimsVol = 2'd3;
  localparam logic [1:0] DimsTwo = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_LIN   = 11'b000_0000_0010,
    S_LEVEL = 11'b000_0000_0100,
    S_FLUSH = 11'b000_0000_1000,
    S_ALQ   = 11'b000_0001_0000,
    S_ALM   = 11'b000_0010_0000,
    S_ALR   = 11'b000_0100_0000,
    S_ALF   = 11'b000_1000_0000,
    S_CUBE  = 11'b001_0000_0000,
    S_DEPTH = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

endpackage : mcts_pkg

`default_nettype wire

[src/mip_chain_texture_size.sv]
// Texture size calculator: one descriptor beat in, one byte length beat out.
// Uses mcts_pkg for the sequencer state type and fixed widths.
//
// Usage: drive one descriptor on the input channel (in_valid_i, in_stall_o);
// the byte length appears on the output channel (out_valid_o, out_stall_i).
// in_stall_o is high from the accepted beat until the result has moved into
// the output register, so one descriptor is in work at a time.
// Sequencer states from acceptance to out_valid_o:
//   linear layout:        S_LIN, S_OUT
//   dims below 2:         S_OUT
//   swizzled mip chain:   S_LEVEL once per saturated level, S_FLUSH, S_ALQ,
//   S_ALM, S_ALR, S_ALF and S_CUBE if cube, S_DEPTH if three dims,
// then S_OUT. One shared 32x32 multiplier does all products but the cube's
// times six (shifts and an add): one mip level per cycle, then the face
// alignment remainder (two products through a reciprocal of FACE_ALIGN) and
// the depth product. The output register frees the sequencer: the next
// descriptor is accepted while a finished length waits for a stalled
// receiver, and it is held in the sequencer until the output frees up.
// Reset clears the sequencer to idle and drops out_valid_o.
`default_nettype none

module mip_chain_texture_size #(
  parameter int unsigned FACE_ALIGN = 128,
  parameter int unsigned MAX_LEVELS = 13
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        is_linear_i,
  input  wire logic        is_compressed_i,
  input  wire logic        small_blocks_i,
  input  wire logic [2:0]  texel_bytes_i,
  input  wire logic [12:0] base_width_i,
  input  wire logic [12:0] base_height_i,
  input  wire logic [9:0]  base_depth_i,
  input  wire logic [15:0] line_stride_i,
  input  wire logic [3:0]  level_count_i,
  input  wire logic        is_cube_i,
  input  wire logic [1:0]  dims_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [35:0]      byte_length_o
);

  localparam int unsigned LvlW  = $clog2(MAX_LEVELS + 1);
  localparam int unsigned AlW   = $clog2(FACE_ALIGN + 1);
  localparam int unsigned RW    = AlW + 1;
  localparam logic [30:0] Recip = 31'((64'd1 << mcts_pkg::RecipSh) / FACE_ALIGN);
  localparam logic [RW-1:0] AlignR = RW'(FACE_ALIGN);

  mcts_pkg::state_e state_q, state_d;

  logic [12:0]           w_q, h_q;
  logic [2:0]            bpp_q;
  logic                  comp_q, small_q, cube_q, dim3_q;
  logic [9:0]            depth_q;
  logic [15:0]           pitch_q;
  logic [LvlW-1:0]       cnt_q;
  logic [mcts_pkg::SumW-1:0] term_q, aux_q;
  logic [mcts_pkg::LenW-1:0] len_q;
  logic [RW-1:0]         r_q;
  logic                  out_valid_q;
  logic [mcts_pkg::LenW-1:0] out_q;

  logic                  in_acc, out_load;
  logic [LvlW-1:0]       lvl_sat;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_p;
  logic [13:0]           w_up, h_up;
  logic [15:0]           bh_blk, hb;
  logic [12:0]           w_half, h_half;
  logic [RW-1:0]         r_fix, pad;

  assign in_stall_o    = (state_q != mcts_pkg::S_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_load      = (state_q == mcts_pkg::S_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o   = out_valid_q;
  assign byte_length_o = out_q;

  assign lvl_sat = ({1'b0, level_count_i} > 5'(MAX_LEVELS)) ? LvlW'(MAX_LEVELS)
                                                            : LvlW'(level_count_i);

  // level operands: 4x4 block counts or texel counts scaled by bytes per pixel
  assign w_up   = 14'(w_q) + 14'd3;
  assign h_up   = 14'(h_q) + 14'd3;
  assign bh_blk = small_q ? {1'b0, h_up[13:2], 3'b000} : {h_up[13:2], 4'b0000};
  assign hb     = ({16{bpp_q[0]}} & 16'(h_q))
                + ({16{bpp_q[1]}} & (16'(h_q) << 1))
                + ({16{bpp_q[2]}} & (16'(h_q) << 2));
  assign w_half = w_q >> 1;
  assign h_half = h_q >> 1;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      mcts_pkg::S_LIN: begin
        mul_a = 32'(h_q);
        mul_b = 32'(pitch_q);
      end
      mcts_pkg::S_LEVEL: begin
        mul_a = comp_q ? 32'(w_up[13:2]) : 32'(w_q);
        mul_b = comp_q ? 32'(bh_blk) : 32'(hb);
      end
      mcts_pkg::S_ALQ: begin
        mul_a = 32'(len_q[mcts_pkg::SumW-1:0]);
        mul_b = 32'(Recip);
      end
      mcts_pkg::S_ALM: begin
        mul_a = 32'(aux_q);
        mul_b = 32'(FACE_ALIGN);
      end
      mcts_pkg::S_DEPTH: begin
        mul_a = len_q[mcts_pkg::MulW-1:0];
        mul_b = 32'(depth_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // remainder is below twice the alignment: one correction, then pad to the boundary
  assign r_fix = (r_q >= AlignR) ? (r_q - AlignR) : r_q;
  assign pad   = (r_fix != '0) ? (AlignR - r_fix) : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcts_pkg::S_IDLE: begin
        if (in_acc) begin
          if (is_linear_i) begin
            state_d = mcts_pkg::S_LIN;
          end else if (dims_i < mcts_pkg::DimsTwo) begin
            state_d = mcts_pkg::S_OUT;
          end else if (lvl_sat == '0) begin
            state_d = mcts_pkg::S_FLUSH;
          end else begin
            state_d = mcts_pkg::S_LEVEL;
          end
        end
      end
      mcts_pkg::S_LIN:   state_d = mcts_pkg::S_OUT;
      mcts_pkg::S_LEVEL: begin
        if (cnt_q == LvlW'(1)) begin
          state_d = mcts_pkg::S_FLUSH;
        end
      end
      mcts_pkg::S_FLUSH: begin
        priority if (cube_q) begin
          state_d = mcts_pkg::S_ALQ;
        end else if (dim3_q) begin
          state_d = mcts_pkg::S_DEPTH;
        end else begin
          state_d = mcts_pkg::S_OUT;
        end
      end
      mcts_pkg::S_ALQ:   state_d = mcts_pkg::S_ALM;
      mcts_pkg::S_ALM:   state_d = mcts_pkg::S_ALR;
      mcts_pkg::S_ALR:   state_d = mcts_pkg::S_ALF;
      mcts_pkg::S_ALF:   state_d = mcts_pkg::S_CUBE;
      mcts_pkg::S_CUBE:  state_d = dim3_q ? mcts_pkg::S_DEPTH : mcts_pkg::S_OUT;
      mcts_pkg::S_DEPTH: state_d = mcts_pkg::S_OUT;
      mcts_pkg::S_OUT: begin
        if (out_load) begin
          state_d = mcts_pkg::S_IDLE;
        end
      end
      default: state_d = mcts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcts_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= len_q;
    end
    unique case (state_q)
      mcts_pkg::S_IDLE: begin
        if (in_acc) begin
          w_q     <= (base_width_i == '0) ? 13'd1 : base_width_i;
          h_q     <= (is_linear_i || base_height_i != '0) ? base_height_i : 13'd1;
          bpp_q   <= texel_bytes_i;
          comp_q  <= is_compressed_i;
          small_q <= small_blocks_i;
          cube_q  <= is_cube_i;
          dim3_q  <= (dims_i == mcts_pkg::DimsVol);
          depth_q <= base_depth_i;
          pitch_q <= line_stride_i;
          cnt_q   <= lvl_sat;
          term_q  <= '0;
          len_q   <= '0;
        end
      end
      mcts_pkg::S_LIN: len_q <= mul_p[mcts_pkg::LenW-1:0];
      mcts_pkg::S_LEVEL: begin
        // accumulate the previous level while this one is multiplied
        term_q <= mul_p[mcts_pkg::SumW-1:0];
        len_q  <= len_q + mcts_pkg::LenW'(term_q);
        w_q    <= (w_half == '0) ? 13'd1 : w_half;
        h_q    <= (h_half == '0) ? 13'd1 : h_half;
        cnt_q  <= cnt_q - LvlW'(1);
      end
      mcts_pkg::S_FLUSH: len_q <= len_q + mcts_pkg::LenW'(term_q);
      mcts_pkg::S_ALQ:   aux_q <= mul_p[mcts_pkg::RecipSh +: mcts_pkg::SumW];
      mcts_pkg::S_ALM:   aux_q <= mul_p[mcts_pkg::SumW-1:0];
      mcts_pkg::S_ALR: begin
        r_q <= RW'(len_q[mcts_pkg::SumW-1:0] - aux_q);
      end
      mcts_pkg::S_ALF:   len_q <= len_q + mcts_pkg::LenW'(pad);
      mcts_pkg::S_CUBE:  len_q <= (len_q << 2) + (len_q << 1);
      mcts_pkg::S_DEPTH: begin
        // saturate lengths that do not fit the result field
        len_q <= (mul_p[63:mcts_pkg::LenW] != '0) ? '1 : mul_p[mcts_pkg::LenW-1:0];
      end
      mcts_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcts_pkg::S_ALF |-> 32'(r_q) < 2 * FACE_ALIGN)
    else $error("alignment remainder out of range");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcts_pkg::S_ALQ |-> len_q[mcts_pkg::LenW-1:mcts_pkg::SumW] == '0)
    else $error("mip chain sum exceeds the reciprocal range");

  a_level_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcts_pkg::S_LEVEL |-> cnt_q != '0)
    else $error("level loop running with no levels left");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != mcts_pkg::S_IDLE)
    else $error("accepted beat did not start the sequencer");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == mcts_pkg::S_IDLE)
    else $error("result load did not free the sequencer");

endmodule : mip_chain_texture_size

`default_nettype wire

[tb/mip_chain_texture_size_test.sv]
// Self-checking testbench for mip_chain_texture_size: texture descriptors in, byte lengths out.
// Depends on mcts_pkg and the block's RTL only; an in-file size predictor checks every length.
`default_nettype none

module mip_chain_texture_size_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FaceAlign   = 128;
  localparam int unsigned MaxLevels   = 13;
  localparam int unsigned LenW        = mcts_pkg::LenW;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleWait  = 40;
  localparam logic [1:0]  DimsNone    = 2'd0;
  localparam logic [1:0]  DimsLine    = 2'd1;
  localparam logic [1:0]  DimsTwo     = mcts_pkg::DimsTwo;
  localparam logic [1:0]  DimsVol     = mcts_pkg::DimsVol;
  localparam longint unsigned LenMax  = (64'd1 << LenW) - 64'd1;

  typedef struct packed {
    logic        is_linear;
    logic        is_compressed;
    logic        small_blocks;
    logic [2:0]  texel_bytes;
    logic [12:0] base_width;
    logic [12:0] base_height;
    logic [9:0]  base_depth;
    logic [15:0] line_stride;
    logic [3:0]  level_count;
    logic        is_cube;
    logic [1:0]  dims;
  } desc_t;

  localparam int unsigned DescW = $bits(desc_t);

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  desc_t drv;
  logic out_valid_o;
  logic out_stall_i;
  logic [LenW-1:0] byte_length_o;

  logic [LenW-1:0] length_q[$];
  int unsigned cycles;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_saturated;
  int unsigned n_cube;
  int unsigned n_volume;
  int unsigned gap_pct;
  int unsigned stall_pct;

  mip_chain_texture_size #(
    .FACE_ALIGN(FaceAlign),
    .MAX_LEVELS(MaxLevels)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .is_linear_i      (drv.is_linear),
    .is_compressed_i  (drv.is_compressed),
    .small_blocks_i   (drv.small_blocks),
    .texel_bytes_i    (drv.texel_bytes),
    .base_width_i     (drv.base_width),
    .base_height_i    (drv.base_height),
    .base_depth_i     (drv.base_depth),
    .line_stride_i    (drv.line_stride),
    .level_count_i    (drv.level_count),
    .is_cube_i        (drv.is_cube),
    .dims_i           (drv.dims),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_length_o    (byte_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    drv         = '0;
  end

  // Expected byte length of one descriptor.
  function automatic logic [LenW-1:0] texture_bytes(desc_t d);
    longint unsigned w, h, levels, total, blk, lv;
    w      = d.base_width;
    h      = d.base_height;
    levels = d.level_count;
    total  = 0;
    blk    = d.small_blocks ? 64'd8 : 64'd16;
    if (d.is_linear) begin
      total = longint'(d.base_height) * longint'(d.line_stride);
    end else if (d.dims >= DimsTwo) begin
      if (levels > MaxLevels) levels = MaxLevels;
      for (lv = 0; lv < levels; lv++) begin
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        if (d.is_compressed) total += ((w + 3) / 4) * ((h + 3) / 4) * blk;
        else total += w * h * d.texel_bytes;
        w = w / 2;
        h = h / 2;
      end
      if (d.is_cube) total = ((total + FaceAlign - 1) / FaceAlign) * FaceAlign * 6;
      if (d.dims == DimsVol) total = total * d.base_depth;
    end
    if (total > LenMax) total = LenMax;
    return total[LenW-1:0];
  endfunction

  function automatic desc_t swizzled(logic [12:0] w, logic [12:0] h, logic [3:0] lv,
                                     logic [1:0] dm);
    desc_t d;
    d                 = '0;
    d.texel_bytes     = 3'd4;
    d.base_width      = w;
    d.base_height     = h;
    d.base_depth      = 10'd1;
    d.level_count     = lv;
    d.dims            = dm;
    return d;
  endfunction

  function automatic logic [12:0] rand_extent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 13'($urandom_range(0, 40));
      4, 5:       return 13'($urandom_range(0, 512));
      6:          return 13'(1 << $urandom_range(0, 12));
      7:          return 13'($urandom_range(4000, 4096));
      default:    return 13'($urandom);
    endcase
  endfunction

  function automatic desc_t rand_desc();
    desc_t d;
    d                 = desc_t'(DescW'({$urandom, $urandom, $urandom}));
    d.is_linear       = ($urandom_range(0, 99) < 12);
    d.base_width      = rand_extent();
    d.base_height     = rand_extent();
    d.level_count     = 4'($urandom_range(0, 15));
    d.is_cube         = ($urandom_range(0, 99) < 30);
    if ($urandom_range(0, 3) != 0) d.texel_bytes = 3'($urandom_range(1, 4));
    if ($urandom_range(0, 9) < 8) d.dims = $urandom_range(0, 1) ? DimsTwo : DimsVol;
    if ($urandom_range(0, 3) != 0) d.base_depth = 10'($urandom_range(0, 8));
    if ($urandom_range(0, 1) != 0) d.line_stride = 16'($urandom_range(0, 4096));
    return d;
  endfunction

  // Send one descriptor; valid stays high into the next beat unless a gap is drawn.
  task automatic send_desc(input desc_t d);
    int unsigned gap;
    gap = ($urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    drv        = d;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    length_q.push_back(texture_bytes(d));
    n_sent++;
    if (texture_bytes(d) == LenMax[LenW-1:0]) n_saturated++;
    if (!d.is_linear && d.dims >= DimsTwo && d.is_cube) n_cube++;
    if (!d.is_linear && d.dims == DimsVol) n_volume++;
  endtask

  // Receiver stalls come in bursts.
  always begin
    @(negedge clk_i);
    if (rst_ni && $urandom_range(1, 100) <= stall_pct) begin
      out_stall_i = 1'b1;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (length_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected length beat, expected none, actual %0d", $time,
                 byte_length_o);
      end else begin
        if (byte_length_o !== length_q[0]) begin
          n_errors++;
          $display("%0t: byte_length mismatch, expected %0d, actual %0d", $time,
                   length_q[0], byte_length_o);
        end
        void'(length_q.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d lengths outstanding", $time, length_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_linear();
    desc_t d;
    d             = '1;
    d.is_linear   = 1'b1;
    send_desc(d);
    d.line_stride = '0;
    send_desc(d);
    d             = '0;
    d.is_linear   = 1'b1;
    d.base_height = 13'd4096;
    d.line_stride = 16'd16384;
    send_desc(d);
    d.base_height = 13'd0;
    d.line_stride = 16'hFFFF;
    send_desc(d);
  endtask

  task automatic test_low_dims();
    desc_t d;
    d = swizzled(13'd256, 13'd256, 4'd9, DimsNone);
    send_desc(d);
    d = swizzled(13'd4096, 13'd1, 4'd13, DimsLine);
    d.is_cube = 1'b1;
    send_desc(d);
  endtask

  task automatic test_uncompressed_chain();
    desc_t d;
    d = swizzled(13'd4096, 13'd4096, 4'd13, DimsTwo);
    send_desc(d);
    d = swizzled(13'd0, 13'd0, 4'd3, DimsTwo);
    send_desc(d);
    // level counts beyond the limit clamp
    d = swizzled(13'd8191, 13'd8191, 4'd15, DimsTwo);
    d.texel_bytes = 3'd7;
    send_desc(d);
    d = swizzled(13'd300, 13'd5, 4'd6, DimsTwo);
    d.texel_bytes = 3'd0;
    send_desc(d);
    d = swizzled(13'd640, 13'd480, 4'd0, DimsTwo);
    send_desc(d);
  endtask

  task automatic test_compressed_chain();
    desc_t d;
    d = swizzled(13'd4096, 13'd4096, 4'd13, DimsTwo);
    d.is_compressed = 1'b1;
    d.small_blocks  = 1'b1;
    send_desc(d);
    d.small_blocks  = 1'b0;
    d.texel_bytes   = 3'd7;
    send_desc(d);
    d = swizzled(13'd13, 13'd7, 4'd5, DimsTwo);
    d.is_compressed = 1'b1;
    send_desc(d);
    d = swizzled(13'd1, 13'd8191, 4'd14, DimsTwo);
    d.is_compressed = 1'b1;
    d.small_blocks  = 1'b1;
    send_desc(d);
  endtask

  task automatic test_cube_and_volume();
    desc_t d;
    d = swizzled(13'd3, 13'd3, 4'd2, DimsTwo);
    d.is_cube = 1'b1;
    send_desc(d);
    // zero levels still take the cube step
    d.level_count = 4'd0;
    send_desc(d);
    d = swizzled(13'd512, 13'd512, 4'd10, DimsVol);
    d.is_cube    = 1'b1;
    d.base_depth = 10'd6;
    send_desc(d);
    d.base_depth = 10'd0;
    send_desc(d);
    d = swizzled(13'd8191, 13'd8191, 4'd13, DimsVol);
    d.texel_bytes = 3'd7;
    d.is_cube    = 1'b1;
    d.base_depth = 10'h3FF;
    send_desc(d);
    d = swizzled(13'd64, 13'd32, 4'd7, DimsVol);
    d.base_depth = 10'd512;
    send_desc(d);
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // vary the input gaps and receiver stalls every 40 beats, with idle-free stretches
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 30;
          default: gap_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          2:       stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      send_desc(rand_desc());
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    gap_pct   = 0;
    stall_pct = 0;
    for (int unsigned i = 0; i < count; i++) send_desc(rand_desc());
  endtask

  initial begin
    cycles      = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_errors    = 0;
    n_saturated = 0;
    n_cube      = 0;
    n_volume    = 0;
    gap_pct     = 25;
    stall_pct   = 25;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_linear();
    test_low_dims();
    test_uncompressed_chain();
    test_compressed_chain();
    test_cube_and_volume();
    test_random(720);
    test_back_to_back(80);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (length_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);

    $display("Sent %0d descriptors (%0d cube, %0d volume), checked %0d lengths,",
             n_sent, n_cube, n_volume, n_checked);
    $display("%0d of them saturated; %0d mismatches.", n_saturated, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[mip_chain_texture_size.f]
src/mcts_pkg.sv
src/mip_chain_texture_size.sv
tb/mip_chain_texture_size_test.sv
